[hw/rtl/rsi_pkg.sv]
// Package with the widths and payload layout shared by the ray/segment intersection block.
package rsi_pkg;

  // Coordinate width of every input and output point field.
  localparam int unsigned CoordBits = 24;
  // Width of a coordinate difference.
  localparam int unsigned DiffBits  = CoordBits + 1;
  // Width of one cross-product term.
  localparam int unsigned ProdBits  = 2 * DiffBits;
  // Width of a sum of two cross-product terms.
  localparam int unsigned SumBits   = ProdBits + 1;
  // Width of the magnitude of a denominator or numerator.
  localparam int unsigned MagBits   = SumBits - 1;
  // Split of the t numerator into two halves for the scaling multiply.
  localparam int unsigned HiBits    = MagBits / 2;
  localparam int unsigned LoBits    = MagBits - HiBits;
  // Width of the dividend t numerator times the wall delta magnitude.
  localparam int unsigned NumBits   = MagBits + DiffBits;
  // Width of the quotient, bounded by the wall delta magnitude.
  localparam int unsigned QuoBits   = DiffBits;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InFieldBits  = 8 * CoordBits;
  localparam int unsigned InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits = 1 + 2 * CoordBits;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  // State of one item inside the divider chain.
  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic                      neg_x;
    logic                      neg_y;
    logic [MagBits-1:0]        den;
    logic [NumBits-1:0]        rem_x;
    logic [NumBits-1:0]        rem_y;
    logic [QuoBits-1:0]        quo_x;
    logic [QuoBits-1:0]        quo_y;
  } div_stage_t;

endpackage

[hw/rtl/ray_segment_intersect_top.sv]
// Pipelined 2D ray versus wall segment intersection test with intersection point.
//
// One beat enters every cycle unless the master side stalls, and passes through six arithmetic
// stages (differences, cross products, sums, sign fold, split scaling multiply, partial
// product sum), then one restoring divider stage per quotient bit (25 stages), then the
// output register. The whole pipeline advances together whenever the output register is
// empty or being taken, so a stall on the master side holds every stage in place.
// hit is 1 when the ray strictly crosses the interior of the wall; the point is then the
// wall start plus t times the wall end minus start, truncated toward zero, and zero otherwise.
module ray_segment_intersect_top
  import rsi_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // From bit 0 up: wall_start_x, wall_start_y, wall_end_x, wall_end_y,
  // ray_origin_x, ray_origin_y, ray_dir_x, ray_dir_y.
  input  logic [InDataBits-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // From bit 0 up: hit, hit_x, hit_y, zero padding.
  output logic [OutDataBits-1:0] m_axis_tdata_o
);

  logic adv;

  logic out_valid_q;
  logic out_hit_q;
  logic [CoordBits-1:0] out_x_q, out_y_q;

  // The pipeline moves when the output register can take a new beat.
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // Input field unpacking.
  logic signed [CoordBits-1:0] in_ax, in_ay, in_bx, in_by, in_ox, in_oy, in_dx, in_dy;
  assign in_ax = s_axis_tdata_i[0*CoordBits +: CoordBits];
  assign in_ay = s_axis_tdata_i[1*CoordBits +: CoordBits];
  assign in_bx = s_axis_tdata_i[2*CoordBits +: CoordBits];
  assign in_by = s_axis_tdata_i[3*CoordBits +: CoordBits];
  assign in_ox = s_axis_tdata_i[4*CoordBits +: CoordBits];
  assign in_oy = s_axis_tdata_i[5*CoordBits +: CoordBits];
  assign in_dx = s_axis_tdata_i[6*CoordBits +: CoordBits];
  assign in_dy = s_axis_tdata_i[7*CoordBits +: CoordBits];

  // Stage 1: wall vector, origin offset and direction.
  logic                       s1_valid_q;
  logic signed [CoordBits-1:0] s1_ax_q, s1_ay_q;
  logic signed [DiffBits-1:0] s1_wx_q, s1_wy_q, s1_px_q, s1_py_q, s1_dx_q, s1_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ax_q <= in_ax;
      s1_ay_q <= in_ay;
      s1_wx_q <= DiffBits'(in_ax) - DiffBits'(in_bx);
      s1_wy_q <= DiffBits'(in_ay) - DiffBits'(in_by);
      s1_px_q <= DiffBits'(in_ax) - DiffBits'(in_ox);
      s1_py_q <= DiffBits'(in_ay) - DiffBits'(in_oy);
      s1_dx_q <= DiffBits'(in_dx);
      s1_dy_q <= DiffBits'(in_dy);
    end
  end

  // Stage 2: the six cross-product terms.
  logic                       s2_valid_q;
  logic signed [CoordBits-1:0] s2_ax_q, s2_ay_q;
  logic signed [DiffBits-1:0] s2_wx_q, s2_wy_q;
  logic signed [ProdBits-1:0] s2_d1_q, s2_d2_q, s2_t1_q, s2_t2_q, s2_u1_q, s2_u2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_ax_q <= s1_ax_q;
      s2_ay_q <= s1_ay_q;
      s2_wx_q <= s1_wx_q;
      s2_wy_q <= s1_wy_q;
      s2_d1_q <= s1_wy_q * s1_dx_q;
      s2_d2_q <= s1_wx_q * s1_dy_q;
      s2_t1_q <= s1_py_q * s1_dx_q;
      s2_t2_q <= s1_px_q * s1_dy_q;
      s2_u1_q <= s1_wy_q * s1_px_q;
      s2_u2_q <= s1_wx_q * s1_py_q;
    end
  end

  // Stage 3: denominator and the t and u numerators.
  logic                       s3_valid_q;
  logic signed [CoordBits-1:0] s3_ax_q, s3_ay_q;
  logic signed [DiffBits-1:0] s3_wx_q, s3_wy_q;
  logic signed [SumBits-1:0]  s3_den_q, s3_tn_q, s3_un_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ax_q  <= s2_ax_q;
      s3_ay_q  <= s2_ay_q;
      s3_wx_q  <= s2_wx_q;
      s3_wy_q  <= s2_wy_q;
      s3_den_q <= SumBits'(s2_d1_q) - SumBits'(s2_d2_q);
      s3_tn_q  <= SumBits'(s2_t1_q) - SumBits'(s2_t2_q);
      s3_un_q  <= SumBits'(s2_u1_q) - SumBits'(s2_u2_q);
    end
  end

  // Stage 4: fold the sign of the denominator, decide the hit, take magnitudes.
  logic signed [SumBits-1:0] s3_den_f, s3_tn_f, s3_un_f;
  logic                      s3_hit;

  always_comb begin
    if (s3_den_q[SumBits-1]) begin
      s3_den_f = -s3_den_q;
      s3_tn_f  = -s3_tn_q;
      s3_un_f  = -s3_un_q;
    end else begin
      s3_den_f = s3_den_q;
      s3_tn_f  = s3_tn_q;
      s3_un_f  = s3_un_q;
    end
    s3_hit = (s3_den_f != '0) && (s3_tn_f > 0) && (s3_tn_f < s3_den_f) && (s3_un_f > 0);
  end

  logic                       s4_valid_q, s4_hit_q;
  logic signed [CoordBits-1:0] s4_ax_q, s4_ay_q;
  logic                       s4_neg_x_q, s4_neg_y_q;
  logic [DiffBits-1:0]        s4_mag_x_q, s4_mag_y_q;
  logic [MagBits-1:0]         s4_den_q, s4_tn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  // The wall delta end minus start is the negated wall vector.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_hit_q   <= s3_hit;
      s4_ax_q    <= s3_ax_q;
      s4_ay_q    <= s3_ay_q;
      s4_neg_x_q <= !s3_wx_q[DiffBits-1];
      s4_neg_y_q <= !s3_wy_q[DiffBits-1];
      s4_mag_x_q <= s3_wx_q[DiffBits-1] ? DiffBits'(-s3_wx_q) : DiffBits'(s3_wx_q);
      s4_mag_y_q <= s3_wy_q[DiffBits-1] ? DiffBits'(-s3_wy_q) : DiffBits'(s3_wy_q);
      s4_den_q   <= s3_den_f[MagBits-1:0];
      s4_tn_q    <= s3_tn_f[MagBits-1:0];
    end
  end

  // Stage 5: partial products of the t numerator halves with the delta magnitudes.
  logic                       s5_valid_q, s5_hit_q;
  logic signed [CoordBits-1:0] s5_ax_q, s5_ay_q;
  logic                       s5_neg_x_q, s5_neg_y_q;
  logic [MagBits-1:0]         s5_den_q;
  logic [LoBits+DiffBits-1:0] s5_lo_x_q, s5_lo_y_q;
  logic [HiBits+DiffBits-1:0] s5_hi_x_q, s5_hi_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (adv) begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_hit_q   <= s4_hit_q;
      s5_ax_q    <= s4_ax_q;
      s5_ay_q    <= s4_ay_q;
      s5_neg_x_q <= s4_neg_x_q;
      s5_neg_y_q <= s4_neg_y_q;
      s5_den_q   <= s4_den_q;
      s5_lo_x_q  <= (LoBits+DiffBits)'(s4_tn_q[LoBits-1:0]) * (LoBits+DiffBits)'(s4_mag_x_q);
      s5_lo_y_q  <= (LoBits+DiffBits)'(s4_tn_q[LoBits-1:0]) * (LoBits+DiffBits)'(s4_mag_y_q);
      s5_hi_x_q  <= (HiBits+DiffBits)'(s4_tn_q[MagBits-1:LoBits]) *
                    (HiBits+DiffBits)'(s4_mag_x_q);
      s5_hi_y_q  <= (HiBits+DiffBits)'(s4_tn_q[MagBits-1:LoBits]) *
                    (HiBits+DiffBits)'(s4_mag_y_q);
    end
  end

  // Stage 6: assemble the dividends and load the divider chain.
  div_stage_t div_q [QuoBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q[0] <= '0;
    end else if (adv) begin
      div_q[0].valid <= s5_valid_q;
      div_q[0].hit   <= s5_hit_q;
      div_q[0].ax    <= s5_ax_q;
      div_q[0].ay    <= s5_ay_q;
      div_q[0].neg_x <= s5_neg_x_q;
      div_q[0].neg_y <= s5_neg_y_q;
      div_q[0].den   <= s5_den_q;
      div_q[0].rem_x <= {s5_hi_x_q, LoBits'(0)} + NumBits'(s5_lo_x_q);
      div_q[0].rem_y <= {s5_hi_y_q, LoBits'(0)} + NumBits'(s5_lo_y_q);
      div_q[0].quo_x <= '0;
      div_q[0].quo_y <= '0;
    end
  end

  // Restoring division, one quotient bit per stage from the top bit down.
  for (genvar g = 0; g < QuoBits; g++) begin : g_div
    localparam int unsigned Shift = QuoBits - 1 - g;
    logic [NumBits:0] dsh, try_x, try_y;
    div_stage_t       nxt;

    always_comb begin
      dsh   = (NumBits+1)'(div_q[g].den) << Shift;
      try_x = {1'b0, div_q[g].rem_x} - dsh;
      try_y = {1'b0, div_q[g].rem_y} - dsh;
      nxt   = div_q[g];
      if (!try_x[NumBits]) begin
        nxt.rem_x        = try_x[NumBits-1:0];
        nxt.quo_x[Shift] = 1'b1;
      end
      if (!try_y[NumBits]) begin
        nxt.rem_y        = try_y[NumBits-1:0];
        nxt.quo_y[Shift] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[g+1] <= '0;
      end else if (adv) begin
        div_q[g+1] <= nxt;
      end
    end
  end

  // Output register: start point plus the signed offset, zero on a miss.
  div_stage_t       last;
  logic [CoordBits-1:0] pt_x, pt_y;

  always_comb begin
    last = div_q[QuoBits];
    pt_x = last.neg_x ? CoordBits'(last.ax) - last.quo_x[CoordBits-1:0]
                      : CoordBits'(last.ax) + last.quo_x[CoordBits-1:0];
    pt_y = last.neg_y ? CoordBits'(last.ay) - last.quo_y[CoordBits-1:0]
                      : CoordBits'(last.ay) + last.quo_y[CoordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_hit_q <= last.hit;
      out_x_q   <= last.hit ? pt_x : '0;
      out_y_q   <= last.hit ? pt_y : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataBits'({out_y_q, out_x_q, out_hit_q});

endmodule
